>>> rtl/core/tce_pkg.sv
`default_nettype none
package tce_pkg;

   localparam int ROWS_DEF = 25;
   localparam int COLS_DEF = 80;
   localparam int POS_W    = 11;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [7:0] CH_NULL    = 8'd0;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] colour;
   } cell_type;

endpackage
`default_nettype wire

>>> rtl/core/tce_if.sv
`default_nettype none
interface tce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] character;
   logic [7:0] colour;
   logic [4:0] read_row;
   logic [6:0] read_col;

   modport source (output valid, opcode, character, colour, read_row, read_col,
                   input ready);
   modport sink   (input valid, opcode, character, colour, read_row, read_col,
                   output ready);
endinterface

interface tce_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_position;
   logic [7:0]  cell_char;
   logic [7:0]  cell_colour;

   modport source (output valid, cursor_position, cell_char, cell_colour,
                   input ready);
   modport sink   (input valid, cursor_position, cell_char, cell_colour,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/core/tce_cell_mem.sv
`default_nettype none
module tce_cell_mem #(
   parameter int DEPTH = tce_pkg::ROWS_DEF * tce_pkg::COLS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     addr,
   input  wire tce_pkg::cell_type wdata,
   output tce_pkg::cell_type      rdata_ff
);

   tce_pkg::cell_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/tce_addr_unit.sv
`default_nettype none
module tce_addr_unit #(
   parameter int COLS = tce_pkg::COLS_DEF,
   parameter int RW   = 5,
   parameter int CW   = 7,
   parameter int AW   = 11
) (
   input  wire logic [RW-1:0] row,
   input  wire logic [CW-1:0] col,
   output logic      [AW-1:0] addr
);

   // linear cell index, row-major
   assign addr = AW'(AW'(row) * AW'(COLS) + AW'(col));

endmodule
`default_nettype wire

>>> rtl/core/text_console_engine.sv
// Character-cell console with a ROWS x COLS cell memory, one cell read or
// written per cycle through a single port, addressed by one shared
// row*COLS+col unit or by a linear counter under a small sequencer. One item
// at a time: an erase drops the character before the cursor, keeping its
// colour, and then scans backward, and a put that scrolls runs a line step,
// a row copy and a blank fill. After reset a clearing pass runs before the
// first item is taken. Every item yields one result with the linear cursor index.
`default_nettype none
module text_console_engine #(
   parameter int ROWS = tce_pkg::ROWS_DEF,
   parameter int COLS = tce_pkg::COLS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tce_req_if.sink   req_chan,
   tce_rsp_if.source rsp_chan
);

   localparam int N  = ROWS * COLS;
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam int AW = $clog2(N);
   localparam int EW = (AW > tce_pkg::POS_W) ? AW : tce_pkg::POS_W;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_PUT      = 4'd2;
   localparam logic [3:0] S_NL       = 4'd3;
   localparam logic [3:0] S_SCR_RD   = 4'd4;
   localparam logic [3:0] S_SCR_WR   = 4'd5;
   localparam logic [3:0] S_FILL     = 4'd6;
   localparam logic [3:0] S_RD_ISS   = 4'd7;
   localparam logic [3:0] S_RD_DAT   = 4'd8;
   localparam logic [3:0] S_ER0      = 4'd9;
   localparam logic [3:0] S_ER_RD0   = 4'd10;
   localparam logic [3:0] S_ER_WR0   = 4'd11;
   localparam logic [3:0] S_SCAN_RD  = 4'd12;
   localparam logic [3:0] S_SCAN_CHK = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
   localparam logic [AW-1:0] CNT_LAST = AW'(N - 1);
   localparam logic [AW-1:0] CPY_LAST = AW'(N - COLS - 1);
   localparam logic [AW-1:0] FILL_1ST = AW'(N - COLS);

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [1:0]    op_ff, op_in;
   logic [7:0]    ch_ff, ch_in;
   logic [7:0]    colour_ff, colour_in;
   logic [4:0]    rrow_ff, rrow_in;
   logic [6:0]    rcol_ff, rcol_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] er_row_ff, er_row_in;
   logic [CW-1:0] er_col_ff, er_col_in;
   logic [7:0]    res_char_ff, res_char_in;
   logic [7:0]    res_col_ff, res_col_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   pos_ff, pos_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic [7:0]    out_col_ff, out_col_in;

   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   tce_pkg::cell_type mem_wdata;
   tce_pkg::cell_type mem_rdata;
   logic [RW-1:0]     u_row;
   logic [CW-1:0]     u_col;
   logic [AW-1:0]     u_addr;
   logic [EW-1:0]     pos_ext;
   logic [RW-1:0]     ss_row;
   logic [CW-1:0]     ss_col;
   logic              accept;

   tce_cell_mem #(.DEPTH(N), .AW(AW)) u_mem (
      .clock    (clock),
      .we       (mem_we),
      .addr     (mem_addr),
      .wdata    (mem_wdata),
      .rdata_ff (mem_rdata)
   );

   tce_addr_unit #(.COLS(COLS), .RW(RW), .CW(CW), .AW(AW)) u_addr_unit (
      .row  (u_row),
      .col  (u_col),
      .addr (u_addr)
   );

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign pos_ext        = EW'(u_addr);

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cursor_position = pos_ff;
   assign rsp_chan.cell_char       = out_char_ff;
   assign rsp_chan.cell_colour     = out_col_ff;

   // where the backward scan of an erase starts
   always_comb begin
      if (cur_col_ff <= CW'(1)) begin
         ss_row = (cur_row_ff != '0) ? cur_row_ff - RW'(1) : '0;
         ss_col = COL_LAST;
      end else begin
         ss_row = cur_row_ff;
         ss_col = cur_col_ff - CW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      colour_in    = colour_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      er_row_in    = er_row_ff;
      er_col_in    = er_col_ff;
      res_char_in  = res_char_ff;
      res_col_in   = res_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pos_in       = pos_ff;
      out_char_in  = out_char_ff;
      out_col_in   = out_col_ff;
      mem_we       = 1'b0;
      mem_addr     = u_addr;
      mem_wdata    = '0;
      u_row        = cur_row_ff;
      u_col        = cur_col_ff;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = '0;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in       = req_chan.opcode;
               ch_in       = req_chan.character;
               colour_in   = req_chan.colour;
               rrow_in     = req_chan.read_row;
               rcol_in     = req_chan.read_col;
               res_char_in = '0;
               res_col_in  = '0;
               case (req_chan.opcode)
                  tce_pkg::OP_PUT:   state_in = S_PUT;
                  tce_pkg::OP_ERASE: state_in = S_ER0;
                  tce_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  default:           state_in = S_RD_ISS;
               endcase
            end
         end
         S_PUT: begin
            if (ch_ff == tce_pkg::CH_NEWLINE) begin
               state_in = S_NL;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = '{ch: ch_ff, colour: colour_ff};
               if (cur_col_ff == COL_LAST) begin
                  state_in = S_NL;
               end else begin
                  cur_col_in = cur_col_ff + CW'(1);
                  state_in   = S_DONE;
               end
            end
         end
         S_NL: begin
            cur_col_in = '0;
            if (cur_row_ff == ROW_LAST) begin
               cnt_in   = '0;
               state_in = S_SCR_RD;
            end else begin
               cur_row_in = cur_row_ff + RW'(1);
               state_in   = S_DONE;
            end
         end
         S_SCR_RD: begin
            mem_addr = AW'(cnt_ff + AW'(COLS));
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = mem_rdata;
            if (cnt_ff == CPY_LAST) begin
               cnt_in   = FILL_1ST;
               state_in = S_FILL;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = S_SCR_RD;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = '{ch: tce_pkg::CH_NULL, colour: colour_ff};
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == CNT_LAST) begin
               cnt_in     = '0;
               cur_col_in = '0;
               if (op_ff == tce_pkg::OP_CLEAR) begin
                  cur_row_in = '0;
               end
               state_in = S_DONE;
            end
         end
         S_RD_ISS: begin
            u_row = RW'(rrow_ff);
            u_col = CW'(rcol_ff);
            if ((32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLS)) begin
               state_in = S_RD_DAT;
            end else begin
               res_char_in = tce_pkg::CH_SPACE;
               res_col_in  = '0;
               state_in    = S_DONE;
            end
         end
         S_RD_DAT: begin
            res_char_in = (mem_rdata.ch == tce_pkg::CH_NULL) ? tce_pkg::CH_SPACE
                                                              : mem_rdata.ch;
            res_col_in  = mem_rdata.colour;
            state_in    = S_DONE;
         end
         S_ER0: begin
            if (cur_col_ff != '0) begin
               er_row_in = cur_row_ff;
               er_col_in = cur_col_ff - CW'(1);
               state_in  = S_ER_RD0;
            end else if (cur_row_ff != '0) begin
               er_row_in = cur_row_ff - RW'(1);
               er_col_in = COL_LAST;
               state_in  = S_ER_RD0;
            end else begin
               er_row_in = ss_row;
               er_col_in = ss_col;
               state_in  = S_SCAN_RD;
            end
         end
         S_ER_RD0: begin
            u_row    = er_row_ff;
            u_col    = er_col_ff;
            state_in = S_ER_WR0;
         end
         S_ER_WR0: begin
            // drop the character, keep the attribute
            u_row     = er_row_ff;
            u_col     = er_col_ff;
            mem_we    = 1'b1;
            mem_wdata = '{ch: tce_pkg::CH_NULL, colour: mem_rdata.colour};
            er_row_in = ss_row;
            er_col_in = ss_col;
            state_in  = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            u_row    = er_row_ff;
            u_col    = er_col_ff;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            state_in = S_DONE;
            if (mem_rdata.ch == tce_pkg::CH_NULL) begin
               if (er_col_ff == '0) begin
                  cur_row_in = er_row_ff;
                  cur_col_in = '0;
               end else begin
                  er_col_in = er_col_ff - CW'(1);
                  state_in  = S_SCAN_RD;
               end
            end else if (er_col_ff == COL_LAST) begin
               if (er_row_ff != ROW_LAST) begin
                  cur_row_in = er_row_ff + RW'(1);
                  cur_col_in = '0;
               end else begin
                  cur_row_in = er_row_ff;
                  cur_col_in = COL_LAST;
               end
            end else begin
               cur_row_in = er_row_ff;
               cur_col_in = er_col_ff + CW'(1);
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               pos_in       = pos_ext[10:0];
               out_char_in  = res_char_ff;
               out_col_in   = res_col_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      colour_ff   <= colour_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      er_row_ff   <= er_row_in;
      er_col_ff   <= er_col_in;
      res_char_ff <= res_char_in;
      res_col_ff  <= res_col_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_col_ff  <= out_col_in;
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_col_ff) < COLS)
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_row_ff) < ROWS)
      else $error("cursor row out of range");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("second item taken while busy");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("finished item without result");

endmodule
`default_nettype wire

>>> dv/text_console_engine_tb.sv
`timescale 1ns / 1ps
module text_console_engine_tb;

   localparam int ROWS = tce_pkg::ROWS_DEF;
   localparam int COLS = tce_pkg::COLS_DEF;
   localparam int N_RANDOM = 1800;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [10:0] pos;
      logic [7:0]  ch;
      logic [7:0]  colour;
   } screen_rsp_type;

   typedef struct {
      logic [1:0]     op;
      logic [7:0]     ch;
      logic [7:0]     colour;
      logic [4:0]     row;
      logic [6:0]     col;
      bit             typed;
      screen_rsp_type rsp;
   } cmd_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   tce_req_if req_chan ();
   tce_rsp_if rsp_chan ();

   text_console_engine #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   tce_pkg::cell_type screen [ROWS][COLS];
   int                cur_row, cur_col;
   screen_rsp_type    rsp_queue [$];
   int                n_errors = 0;
   int                n_rsp = 0;
   int                n_read = 0, n_erase = 0, n_scroll = 0;
   int                idle_cycles = 0;
   bit                rsp_idle_on = 1'b1;
   bit                timed_out = 1'b0;
   cmd_row_type       cmd_table [$];

   task automatic screen_reset(input logic [7:0] colour);
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++) begin
            screen[r][c].ch = tce_pkg::CH_NULL;
            screen[r][c].colour = colour;
         end
      cur_row = 0;
      cur_col = 0;
   endtask

   task automatic line_feed(input logic [7:0] colour);
      if (cur_row + 1 >= ROWS) begin
         n_scroll++;
         for (int r = 0; r + 1 < ROWS; r++)
            for (int c = 0; c < COLS; c++) screen[r][c] = screen[r + 1][c];
         for (int c = 0; c < COLS; c++) begin
            screen[ROWS - 1][c].ch = tce_pkg::CH_NULL;
            screen[ROWS - 1][c].colour = colour;
         end
      end else begin
         cur_row++;
      end
      cur_col = 0;
   endtask

   task automatic console_apply(input logic [1:0] op, input logic [7:0] ch,
                                input logic [7:0] colour, input logic [4:0] row,
                                input logic [6:0] col, output screen_rsp_type rsp);
      int x, y;
      rsp = '0;
      case (op)
         tce_pkg::OP_PUT: begin
            if (ch == tce_pkg::CH_NEWLINE) begin
               line_feed(colour);
            end else begin
               screen[cur_row][cur_col].ch = ch;
               screen[cur_row][cur_col].colour = colour;
               cur_col++;
               if (cur_col >= COLS) line_feed(colour);
            end
         end
         tce_pkg::OP_ERASE: begin
            n_erase++;
            x = cur_col - 1;
            y = cur_row;
            if (x >= 0) screen[y][x].ch = tce_pkg::CH_NULL;
            else if (y > 0) screen[y - 1][COLS - 1].ch = tce_pkg::CH_NULL;
            if (x <= 0) begin
               x = COLS - 1;
               y = (y > 0) ? y - 1 : 0;
            end
            while (x >= 0 && screen[y][x].ch == tce_pkg::CH_NULL) x--;
            x++;
            if (x >= COLS) begin
               if (y + 1 < ROWS) begin
                  y++;
                  x = 0;
               end else begin
                  x = COLS - 1;
               end
            end
            cur_row = y;
            cur_col = x;
         end
         tce_pkg::OP_CLEAR: screen_reset(colour);
         default: begin
            n_read++;
            if (row < ROWS && col < COLS) begin
               rsp.ch = screen[row][col].ch;
               rsp.colour = screen[row][col].colour;
               if (rsp.ch == tce_pkg::CH_NULL) rsp.ch = tce_pkg::CH_SPACE;
            end else begin
               rsp.ch = tce_pkg::CH_SPACE;
            end
         end
      endcase
      rsp.pos = 11'(cur_row * COLS + cur_col);
   endtask

   function automatic cmd_row_type mk(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [7:0] colour, input logic [4:0] row,
                                      input logic [6:0] col);
      cmd_row_type t;
      t.op = op; t.ch = ch; t.colour = colour; t.row = row; t.col = col;
      t.typed = 1'b0; t.rsp = '0;
      return t;
   endfunction

   function automatic cmd_row_type mk_typed(input cmd_row_type t, input logic [10:0] pos,
                                            input logic [7:0] ch,
                                            input logic [7:0] colour);
      t.typed = 1'b1;
      t.rsp.pos = pos; t.rsp.ch = ch; t.rsp.colour = colour;
      return t;
   endfunction

   // entered at a falling edge; leaves valid high after the beat so that
   // the next item can follow at once
   task automatic send_cmd(input cmd_row_type t, input int idle_pct);
      screen_rsp_type rsp;
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= t.op;
      req_chan.character <= t.ch;
      req_chan.colour   <= t.colour;
      req_chan.read_row <= t.row;
      req_chan.read_col <= t.col;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      console_apply(t.op, t.ch, t.colour, t.row, t.col, rsp);
      if (t.typed && rsp != t.rsp) begin
         n_errors++;
         if (n_errors <= 10)
            $display("table row op %0d: expected %h, model gives %h", t.op, t.rsp, rsp);
      end
      rsp_queue.push_back(rsp);
      @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         screen_rsp_type got, want;
         got = '{rsp_chan.cursor_position, rsp_chan.cell_char, rsp_chan.cell_colour};
         if (rsp_queue.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected response %h", got);
         end else begin
            want = rsp_queue.pop_front();
            n_rsp++;
            if (got != want) begin
               n_errors++;
               if (n_errors <= 10)
                  $display({"mismatch: expected pos %0d char %h colour %h,",
                            " got pos %0d char %h colour %h"},
                           want.pos, want.ch, want.colour, got.pos, got.ch, got.colour);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_chan.ready <= rsp_idle_on ? ($urandom_range(99) >= 29) : 1'b1;

   // watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired, %0d responses outstanding", rsp_queue.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      cmd_row_type t;
      int op_pick, pct, waited;
      req_chan.valid = 1'b0;
      req_chan.opcode = tce_pkg::OP_PUT;
      req_chan.character = '0;
      req_chan.colour = '0;
      req_chan.read_row = '0;
      req_chan.read_col = '0;
      rsp_chan.ready = 1'b0;
      screen_reset(8'd0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_READ, '0, '0, '0, '0),
                                   '0, tce_pkg::CH_SPACE, '0));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_READ, '0, '0, 5'd31, 7'd127),
                                   '0, tce_pkg::CH_SPACE, '0));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_ERASE, '0, '0, '0, '0), '0, '0, '0));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_PUT, 8'hFF, 8'hFF, '0, '0),
                                   11'd1, '0, '0));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_READ, '0, '0, '0, '0),
                                   11'd1, 8'hFF, 8'hFF));
      cmd_table.push_back(mk(tce_pkg::OP_PUT, 8'd0, 8'h55, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_PUT, 8'h41, 8'hAA, 5'd31, 7'd127));
      cmd_table.push_back(mk(tce_pkg::OP_ERASE, '0, '0, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_ERASE, '0, '0, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_READ, '0, '0, '0, 7'd2));
      cmd_table.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CH_NEWLINE, 8'h17, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_ERASE, '0, '0, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_READ, '0, '0, 5'd24, 7'd79));
      cmd_table.push_back(mk(tce_pkg::OP_READ, '0, '0, 5'd25, '0));
      cmd_table.push_back(mk(tce_pkg::OP_READ, '0, '0, '0, 7'd80));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_CLEAR, '0, 8'h3C, '0, '0), '0, '0, '0));
      cmd_table.push_back(mk_typed(mk(tce_pkg::OP_READ, '0, '0, 5'd24, 7'd79),
                                   '0, tce_pkg::CH_SPACE, 8'h3C));
      // newlines down to the bottom row, then one more to scroll
      for (int i = 0; i < ROWS; i++)
         cmd_table.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CH_NEWLINE, 8'h71, '0, '0));
      cmd_table.push_back(mk(tce_pkg::OP_READ, '0, '0, 5'd24, 7'd5));
      cmd_table.push_back(mk(tce_pkg::OP_ERASE, '0, '0, '0, '0));
      foreach (cmd_table[i]) send_cmd(cmd_table[i], 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         // quiet middle stretch with no idling on either side
         rsp_idle_on = !(i >= 600 && i < 900);
         pct = rsp_idle_on ? 29 : 0;
         if (i == 1200) begin
            // hold the sender until every result is back
            req_chan.valid <= 1'b0;
            @(negedge clock);
            waited = 0;
            while (rsp_queue.size() != 0 && waited < 100000) begin
               @(negedge clock);
               waited++;
            end
         end
         op_pick = $urandom_range(99);
         if (op_pick < 55)
            t = mk(tce_pkg::OP_PUT,
                   ($urandom_range(5) == 0) ? tce_pkg::CH_NEWLINE : 8'($urandom),
                   8'($urandom), 5'($urandom), 7'($urandom));
         else if (op_pick < 72)
            t = mk(tce_pkg::OP_ERASE, 8'($urandom), 8'($urandom), 5'($urandom),
                   7'($urandom));
         else if (op_pick < 74)
            t = mk(tce_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom),
                   7'($urandom));
         else if ($urandom_range(9) == 0)
            t = mk(tce_pkg::OP_READ, 8'($urandom), 8'($urandom), 5'($urandom),
                   7'($urandom));
         else
            t = mk(tce_pkg::OP_READ, 8'($urandom), 8'($urandom),
                   5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
         send_cmd(t, pct);
      end
      req_chan.valid <= 1'b0;

      waited = 0;
      while (rsp_queue.size() != 0 && !timed_out) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d responses checked: %0d reads, %0d erases, %0d scrolls",
               n_rsp, n_read, n_erase, n_scroll);
      if (n_errors == 0 && rsp_queue.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/tce_pkg.sv
rtl/core/tce_if.sv
rtl/core/tce_cell_mem.sv
rtl/core/tce_addr_unit.sv
rtl/core/text_console_engine.sv
dv/text_console_engine_tb.sv
